[rtl/core/lsc_pkg.sv]
// Package for the LRU sector cache tag manager: sizes, word types and
// the scan and update records passed along the cell row. No dependencies.
`timescale 1ns / 1ps

package lsc_pkg;

    localparam int ENTRIES     = 8;
    localparam int SECTOR_BITS = 16;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W      = IDX_W;

    // update operations broadcast to the cells
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_EVICT = 2'd1;
    localparam logic [1:0] OP_HIT   = 2'd2;
    localparam logic [1:0] OP_FILL  = 2'd3;

    // request functions
    localparam logic FUNC_ACCESS = 1'b0;
    localparam logic FUNC_EVICT  = 1'b1;

    typedef struct packed {
        logic                   func;
        logic [SECTOR_BITS-1:0] sector;
        logic                   is_write;
    } in_t;

    typedef struct packed {
        logic                   hit;
        logic [IDX_W-1:0]       slot;
        logic                   fetch;
        logic                   evicted;
        logic [SECTOR_BITS-1:0] evicted_sector;
        logic                   write_back;
    } out_t;

    // running search result handed from cell to cell
    typedef struct packed {
        logic                   hit_found;
        logic [IDX_W-1:0]       hit_idx;
        logic [RANK_W-1:0]      hit_rank;
        logic                   free_found;
        logic [IDX_W-1:0]       free_idx;
        logic                   old_found;
        logic [IDX_W-1:0]       old_idx;
        logic [RANK_W-1:0]      old_rank;
        logic [SECTOR_BITS-1:0] old_tag;
        logic                   old_dirty;
    } scan_t;

    typedef struct packed {
        logic [1:0]             op;
        logic [IDX_W-1:0]       idx;
        logic                   is_write;
        logic [SECTOR_BITS-1:0] sector;
        logic [RANK_W-1:0]      hit_rank;
    } upd_t;

endpackage

[rtl/core/lsc_cell.sv]
// One cache entry of the LRU sector cache: tag, valid, dirty and rank,
// plus one registered stage of the search chain. Depends on lsc_pkg.
`timescale 1ns / 1ps

module lsc_cell
    import lsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IDX_W-1:0]       cell_idx,
    input  logic [SECTOR_BITS-1:0] sector,
    input  scan_t                  scan_in,
    output scan_t                  scan_out,
    input  upd_t                   upd
);

    logic [SECTOR_BITS-1:0] tag_reg;
    logic                   valid_reg;
    logic                   dirty_reg;
    logic [RANK_W-1:0]      rank_reg;
    scan_t                  scan_reg;
    scan_t                  scan_next;
    logic                   mine;

    always_comb
    begin
        scan_next = scan_in;
        if (!scan_in.hit_found && valid_reg && (tag_reg == sector))
        begin
            scan_next.hit_found = 1'b1;
            scan_next.hit_idx   = cell_idx;
            scan_next.hit_rank  = rank_reg;
        end
        if (!scan_in.free_found && !valid_reg)
        begin
            scan_next.free_found = 1'b1;
            scan_next.free_idx   = cell_idx;
        end
        // strictly greater keeps the lowest index among equal ranks
        if (valid_reg && (!scan_in.old_found || (rank_reg > scan_in.old_rank)))
        begin
            scan_next.old_found = 1'b1;
            scan_next.old_idx   = cell_idx;
            scan_next.old_rank  = rank_reg;
            scan_next.old_tag   = tag_reg;
            scan_next.old_dirty = dirty_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
        end
    end

    assign scan_out = scan_reg;
    assign mine     = (upd.idx == cell_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            case (upd.op)
                OP_EVICT:
                begin
                    if (mine)
                    begin
                        valid_reg <= 1'b0;
                        dirty_reg <= 1'b0;
                        rank_reg  <= '0;
                    end
                end
                OP_HIT:
                begin
                    if (mine)
                    begin
                        dirty_reg <= dirty_reg | upd.is_write;
                        rank_reg  <= '0;
                    end
                    else if (valid_reg && (rank_reg < upd.hit_rank))
                    begin
                        rank_reg <= rank_reg + RANK_W'(1);
                    end
                end
                OP_FILL:
                begin
                    if (mine)
                    begin
                        valid_reg <= 1'b1;
                        dirty_reg <= upd.is_write;
                        rank_reg  <= '0;
                    end
                    else if (valid_reg)
                    begin
                        rank_reg <= rank_reg + RANK_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // tags carry no reset; they are only looked at while valid
    always_ff @(posedge clk)
    begin
        if ((upd.op == OP_FILL) && mine)
        begin
            tag_reg <= upd.sector;
        end
    end

endmodule

[rtl/core/lru_sector_cache_tags.sv]
// Top level of the LRU sector cache tag manager: request control, the
// row of entry cells and the result register. Depends on lsc_pkg, lsc_cell.
`timescale 1ns / 1ps

// Usage:
//   A request word (func, sector, is_write) is taken at a rising edge with
//   start high and busy low. busy stays high while the request is handled.
//   The result word appears on result for exactly one cycle with done high;
//   the receiver must take it then, there is no back-pressure.
// Timing:
//   The search runs down the row of ENTRIES cells, one cell per cycle, then
//   the S_APPLY state applies the update and registers the result. busy is
//   already low while done is high, so a new word can be taken at the edge
//   that ends it; a new request is taken only after the last one is done.
//   The length of the cell chain sets the time each request takes.
// Reset:
//   rst_n clears all valid and dirty bits and the ranks; the cache is empty
//   and idle. Tags hold no value until an entry is filled.
module lru_sector_cache_tags
    import lsc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  req,
    output logic done,
    output out_t result
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    in_t              req_reg;
    out_t             result_reg;
    out_t             result_next;
    logic             done_reg;
    upd_t             upd;
    scan_t            scan_link [ENTRIES+1];
    scan_t            scan_res;

    assign scan_link[0] = '0;
    assign scan_res     = scan_link[ENTRIES];

    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_cell
        lsc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(k)),
            .sector   (req_reg.sector),
            .scan_in  (scan_link[k]),
            .scan_out (scan_link[k+1]),
            .upd      (upd)
        );
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // decide the update from the finished search
    always_comb
    begin
        upd          = '0;
        upd.op       = OP_NONE;
        upd.is_write = req_reg.is_write;
        upd.sector   = req_reg.sector;
        upd.hit_rank = scan_res.hit_rank;
        result_next  = '0;
        if (state_reg == S_APPLY)
        begin
            if (req_reg.func == FUNC_EVICT)
            begin
                if (scan_res.old_found)
                begin
                    upd.op                     = OP_EVICT;
                    upd.idx                    = scan_res.old_idx;
                    result_next.slot           = scan_res.old_idx;
                    result_next.evicted        = 1'b1;
                    result_next.evicted_sector = scan_res.old_tag;
                    result_next.write_back     = scan_res.old_dirty;
                end
            end
            else if (scan_res.hit_found)
            begin
                upd.op           = OP_HIT;
                upd.idx          = scan_res.hit_idx;
                result_next.hit  = 1'b1;
                result_next.slot = scan_res.hit_idx;
            end
            else
            begin
                upd.op            = OP_FILL;
                result_next.fetch = 1'b1;
                if (scan_res.free_found)
                begin
                    upd.idx = scan_res.free_idx;
                end
                else
                begin
                    // full: replace the least recent entry
                    upd.idx                    = scan_res.old_idx;
                    result_next.evicted        = 1'b1;
                    result_next.evicted_sector = scan_res.old_tag;
                    result_next.write_back     = scan_res.old_dirty;
                end
                result_next.slot = upd.idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= (state_reg == S_APPLY);
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            req_reg <= req;
        end
        if (state_reg == S_APPLY)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted word did not start a request");

    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.hit) |-> (!result.fetch && !result.evicted))
        else $error("hit reported with fetch or eviction");

    a_wb_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.write_back) |-> result.evicted)
        else $error("write-back without eviction");
`endif

endmodule
